### rtl/core/sorted_step_table_lookup_unit_macros.svh
// Assertion helpers used by the sorted step table lookup unit.
`ifndef SORTED_STEP_TABLE_LOOKUP_UNIT_MACROS_SVH
`define SORTED_STEP_TABLE_LOOKUP_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SSTL_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/sstl_pkg.sv
`default_nettype none
package sstl_pkg;

	localparam int unsigned DW = 32;

	// request opcode
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// response status
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BELOW = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// control sequencer states
	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_SCAN = 2'd1,
		FSM_DONE = 2'd2
	} fsm_t;

	typedef struct packed {
		op_t                  op;
		logic signed [DW-1:0] key;
		logic signed [DW-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DW-1:0] bin_value;
		logic signed [DW-1:0] bin_base;
		status_t              status;
	} rsp_t;

	// one table entry as held by a cell
	typedef struct packed {
		logic signed [DW-1:0] base;
		logic signed [DW-1:0] value;
	} entry_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic   ins;
		logic   rot;
		entry_t new_entry;
	} cell_ctl_t;

endpackage
`default_nettype wire

### rtl/core/sstl_if.sv
`default_nettype none
// valid/ready channel carrying one payload struct
interface sstl_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/sstl_cell.sv
`default_nettype none
// One slot of the sorted table. Inserts shift the upper part of the row
// up by one; rotation moves every entry one place towards cell 0.
module sstl_cell (
	input  wire logic               clk,
	input  wire sstl_pkg::cell_ctl_t ctl,
	input  wire logic               occupied,
	input  wire logic               prev_above,
	input  wire sstl_pkg::entry_t   left_entry,
	input  wire sstl_pkg::entry_t   right_entry,
	output sstl_pkg::entry_t        entry,
	output logic                    above
);

	sstl_pkg::entry_t entry_q;

	// empty slots count as above any key, so the new pair lands after equal bases
	assign above = !occupied || (entry_q.base > ctl.new_entry.base);
	assign entry = entry_q;

	// slot update: rotate, or take neighbour / new pair on insert
	always_ff @(posedge clk) begin
		if (ctl.rot) begin
			entry_q <= right_entry;
		end else if (ctl.ins && above) begin
			if (prev_above) begin
				entry_q <= left_entry;
			end else begin
				entry_q <= ctl.new_entry;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/sorted_step_table_lookup_unit.sv
// Channel | Dir | Payload                      | Handshake
// req     | in  | op, key, value               | valid/ready
// rsp     | out | bin_value, bin_base, status  | valid/ready
//
// Insert: table updated at the accepting edge; the response is then registered
// in the DONE state. Lookup: the SCAN state rotates the cell row past cell 0,
// then the DONE state registers the result. DONE holds while an earlier
// response still waits on rsp.ready, and a new request is taken only in IDLE.
// Reset clears the entry count, FSM state and rsp.valid; cells need no clearing pass.
// A new request is taken while the previous response waits on rsp.ready.
`default_nettype none
`include "sorted_step_table_lookup_unit_macros.svh"
module sorted_step_table_lookup_unit #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	sstl_stream_if.sink       req,
	sstl_stream_if.source     rsp
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = $clog2(DEPTH);

	sstl_pkg::fsm_t      fsm_q, fsm_d;
	logic [CW-1:0]       count_q;
	logic [IW-1:0]       step_q;
	logic signed [sstl_pkg::DW-1:0] key_q;
	sstl_pkg::rsp_t      res_q;
	sstl_pkg::rsp_t      out_q;
	logic                out_valid_q;

	logic                req_fire;
	logic                is_full;
	logic                scan_last;
	logic                scan_hit;
	logic                out_load;
	sstl_pkg::cell_ctl_t ctl;

	sstl_pkg::entry_t    ent [DEPTH];
	logic                above [DEPTH];

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sstl_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (CW'(i) < count_q),
			.prev_above  ((i == 0) ? 1'b0 : above[(i == 0) ? 0 : i - 1]),
			.left_entry  (ent[(i == 0) ? 0 : i - 1]),
			.right_entry (ent[(i + 1) % DEPTH]),
			.entry       (ent[i]),
			.above       (above[i])
		);
	end

	assign is_full   = (count_q == CW'(DEPTH));
	assign req_fire  = req.valid && req.ready;
	assign scan_last = (step_q == IW'(DEPTH - 1));
	// entry now at cell 0 is original slot step_q
	assign scan_hit  = (CW'(step_q) < count_q) && (ent[0].base <= key_q);

	// next state
	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			sstl_pkg::FSM_IDLE: begin
				if (req_fire) begin
					fsm_d = (req.data.op == sstl_pkg::OP_LOOKUP) ? sstl_pkg::FSM_SCAN
						: sstl_pkg::FSM_DONE;
				end
			end
			sstl_pkg::FSM_SCAN: begin
				if (scan_last) begin
					fsm_d = sstl_pkg::FSM_DONE;
				end
			end
			sstl_pkg::FSM_DONE: begin
				if (out_load) begin
					fsm_d = sstl_pkg::FSM_IDLE;
				end
			end
			default: fsm_d = sstl_pkg::FSM_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready               = (fsm_q == sstl_pkg::FSM_IDLE);
		out_load                = (fsm_q == sstl_pkg::FSM_DONE) && (!out_valid_q || rsp.ready);
		ctl.ins                 = req_fire && (req.data.op == sstl_pkg::OP_INSERT) && !is_full;
		ctl.rot                 = (fsm_q == sstl_pkg::FSM_SCAN);
		ctl.new_entry.base      = req.data.key;
		ctl.new_entry.value     = req.data.value;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= sstl_pkg::FSM_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			if (ctl.ins) begin
				count_q <= count_q + CW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan counter, search key and pending result
	always_ff @(posedge clk) begin
		if (req_fire) begin
			step_q           <= '0;
			key_q            <= req.data.key;
			res_q.bin_value  <= '0;
			res_q.bin_base   <= '0;
			if (req.data.op == sstl_pkg::OP_LOOKUP) begin
				res_q.status <= sstl_pkg::ST_BELOW;
			end else if (is_full) begin
				res_q.status <= sstl_pkg::ST_FULL;
			end else begin
				res_q.status <= sstl_pkg::ST_OK;
			end
		end else if (fsm_q == sstl_pkg::FSM_SCAN) begin
			step_q <= step_q + IW'(1);
			// ascending order: the last hit is the floor bin
			if (scan_hit) begin
				res_q.bin_value <= ent[0].value;
				res_q.bin_base  <= ent[0].base;
				res_q.status    <= sstl_pkg::ST_OK;
			end
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	`SSTL_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH),
		"entry count beyond table depth")
	`SSTL_ASSERT_NEXT(a_lookup_starts_scan, clk, arst_n,
		req_fire && (req.data.op == sstl_pkg::OP_LOOKUP),
		(fsm_q == sstl_pkg::FSM_SCAN) && (step_q == '0) && $stable(count_q),
		"lookup did not start a fresh scan")
	`SSTL_ASSERT_NEXT(a_insert_counts, clk, arst_n,
		req_fire && (req.data.op == sstl_pkg::OP_INSERT),
		count_q == ($past(count_q) + CW'(!$past(is_full))),
		"insert changed entry count wrongly")
	`SSTL_ASSERT_NEXT(a_full_status, clk, arst_n,
		req_fire && (req.data.op == sstl_pkg::OP_INSERT) && is_full,
		res_q.status == sstl_pkg::ST_FULL,
		"insert into full table not flagged")

endmodule
`default_nettype wire
